@@ rtl/core/btfre_pkg.sv @@
// Shared types, constants and the cell remapping function of the tile flip/rotate engine.
// No dependencies; used by btfre_bank, block_tile_flip_rotate_engine and the testbench.

package btfre_pkg;

  // Grid geometry and cell data.
  localparam int MAX_LOG_SIZE = 7;
  localparam int DATA_WIDTH   = 16;
  localparam int COORD_W      = MAX_LOG_SIZE;
  localparam int ADDR_W       = 2 * MAX_LOG_SIZE;
  localparam int CELL_COUNT   = 1 << ADDR_W;
  localparam int LOG_W        = 3;

  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [LOG_W-1:0]      log_t;

  // Item operations.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_XFORM = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Transform codes.
  typedef enum logic [2:0] {
    XF_FLIP_ROWS    = 3'd0,
    XF_FLIP_COLS    = 3'd1,
    XF_ROT_TILE_CW  = 3'd2,
    XF_ROT_TILE_CCW = 3'd3,
    XF_REV_ROWS     = 3'd4,
    XF_REV_COLS     = 3'd5,
    XF_ROT_ARR_CW   = 3'd6,
    XF_ROT_ARR_CCW  = 3'd7
  } xform_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // A cell position.
  typedef struct packed {
    coord_t row;
    coord_t col;
  } cell_t;

  // One bank access in a cycle: a write and a read.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } bank_req_t;

  // Mask of the low lg bits (lg up to MAX_LOG_SIZE).
  function automatic coord_t low_mask(log_t lg);
    logic [COORD_W:0] one_hot;
    one_hot = (COORD_W+1)'(1) << lg;
    return coord_t'(one_hot - (COORD_W+1)'(1));
  endfunction

  // Where a source cell lands. om masks the offset inside a tile, nm the grid.
  // Offsets inside a full tile mask are reversed by XOR, tile indices likewise
  // by XOR with the tile-index bits of the grid.
  function automatic cell_t dest_cell(xform_t xf, cell_t src, coord_t om, coord_t nm);
    cell_t  d;
    coord_t hi;
    coord_t r;
    coord_t c;
    r  = src.row;
    c  = src.col;
    hi = nm & ~om;
    d  = src;
    unique case (xf)
      XF_FLIP_ROWS:    d.row = r ^ om;
      XF_FLIP_COLS:    d.col = c ^ om;
      XF_ROT_TILE_CW: begin
        d.row = (r & ~om) | (c & om);
        d.col = (c & ~om) | (~r & om);
      end
      XF_ROT_TILE_CCW: begin
        d.row = (r & ~om) | (~c & om);
        d.col = (c & ~om) | (r & om);
      end
      XF_REV_ROWS:     d.row = r ^ hi;
      XF_REV_COLS:     d.col = c ^ hi;
      XF_ROT_ARR_CW: begin
        d.row = (c & ~om) | (r & om);
        d.col = ((r & ~om) ^ hi) | (c & om);
      end
      XF_ROT_ARR_CCW: begin
        d.row = ((c & ~om) ^ hi) | (r & om);
        d.col = (r & ~om) | (c & om);
      end
    endcase
    d.row = d.row & nm;
    d.col = d.col & nm;
    return d;
  endfunction

endpackage

@@ rtl/core/btfre_bank.sv @@
// One grid bank: a synchronous single-write, single-read memory with registered read data.
// Depends on btfre_pkg for the address, data and request types.

module btfre_bank (
  input  logic                 clk,
  input  btfre_pkg::bank_req_t req,
  output btfre_pkg::data_t     rdata
);

  btfre_pkg::data_t mem [btfre_pkg::CELL_COUNT];
  btfre_pkg::data_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/block_tile_flip_rotate_engine.sv @@
// Top level of the tile flip/rotate engine: handshakes, sequencer and two grid banks.
// Depends on btfre_pkg and btfre_bank.
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+----------------------------------------------------------
//  in_      | slave     | tuser: operation; tdata: row, col, cell_value, transform, level
//  out_     | master    | tuser: status; tdata: read_value
//  cfg_     | write     | cfg_wr_data: grid_log_size, taken whenever cfg_wr_en is high
//
// A transform streams every cell of the active N x N grid through the active
// bank's single read port, one cell per cycle.
// Reset clears the sequencer, the bank select and the output valid and sets the
// grid size to its maximum; cell contents are undefined until written. A new beat
// is taken while the last result still waits in the output register; a finished
// item waits in the done state until the output register is free.

module block_tile_flip_rotate_engine (
  input  logic        clk,
  input  logic        rst_n,
  // Input beats.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] operation
  input  logic [39:0] in_tdata,   // [6:0] row, [13:7] col, [29:14] cell_value,
                                  // [32:30] transform, [35:33] level, rest zero
  // Result beats.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // [0] status
  output logic [15:0] out_tdata,  // [15:0] read_value
  // Configuration.
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data // grid_log_size
);

  // Field decode.
  btfre_pkg::op_t    in_op;
  btfre_pkg::cell_t  in_cell;
  btfre_pkg::data_t  in_value;
  btfre_pkg::xform_t in_xf;
  btfre_pkg::log_t   in_lvl;
  logic              in_acc;

  assign in_op    = btfre_pkg::op_t'(in_tuser);
  assign in_value = in_tdata[29:14];
  assign in_xf    = btfre_pkg::xform_t'(in_tdata[32:30]);
  assign in_lvl   = in_tdata[35:33];
  assign in_acc   = in_tvalid && in_tready;

  // Registers.
  btfre_pkg::state_t state_r, state_nxt;
  logic              bank_r;
  btfre_pkg::log_t   size_r;
  btfre_pkg::xform_t xf_r;
  btfre_pkg::log_t   lvl_r;
  btfre_pkg::coord_t scan_row_r;
  btfre_pkg::coord_t scan_col_r;
  logic              wr_vld_r;
  btfre_pkg::addr_t  wr_addr_r;
  logic              pend_status_r;
  btfre_pkg::data_t  pend_data_r;
  logic              out_valid_r;
  logic              out_status_r;
  btfre_pkg::data_t  out_data_r;

  // Size in use and its masks.
  btfre_pkg::log_t   size_use;
  btfre_pkg::coord_t nm;
  btfre_pkg::coord_t om;
  logic              lvl_bad;
  logic              scan_last;
  logic              out_free;
  btfre_pkg::cell_t  scan_cell;
  btfre_pkg::cell_t  scan_dest;

  assign size_use = (size_r == '0) ? btfre_pkg::log_t'(1) : size_r;
  assign nm       = btfre_pkg::low_mask(size_use);
  assign om       = btfre_pkg::low_mask(lvl_r);
  assign lvl_bad  = in_lvl > size_use;
  assign in_cell.row = in_tdata[6:0] & nm;
  assign in_cell.col = in_tdata[13:7] & nm;

  assign scan_cell.row = scan_row_r;
  assign scan_cell.col = scan_col_r;
  assign scan_dest     = btfre_pkg::dest_cell(xf_r, scan_cell, om, nm);
  assign scan_last     = (scan_row_r == nm) && (scan_col_r == nm);
  assign out_free      = !out_valid_r || out_tready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= btfre_pkg::log_t'(btfre_pkg::MAX_LOG_SIZE);
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btfre_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and input ready.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      btfre_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          priority if (in_op == btfre_pkg::OP_READ) begin
            state_nxt = btfre_pkg::ST_READ;
          end else if (in_op == btfre_pkg::OP_XFORM && !lvl_bad) begin
            state_nxt = btfre_pkg::ST_SCAN;
          end else begin
            state_nxt = btfre_pkg::ST_DONE;
          end
        end
      end
      btfre_pkg::ST_READ:  state_nxt = btfre_pkg::ST_DONE;
      btfre_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = btfre_pkg::ST_DRAIN;
        end
      end
      btfre_pkg::ST_DRAIN: state_nxt = btfre_pkg::ST_DONE;
      btfre_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = btfre_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btfre_pkg::ST_IDLE;
    endcase
  end

  // Bank select: the banks swap roles once the last moved cell is written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
    end else if (state_r == btfre_pkg::ST_DRAIN) begin
      bank_r <= ~bank_r;
    end
  end

  // Item capture and the row-major scan counters.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      xf_r       <= in_xf;
      lvl_r      <= in_lvl;
      scan_row_r <= '0;
      scan_col_r <= '0;
    end else if (state_r == btfre_pkg::ST_SCAN) begin
      if (scan_col_r == nm) begin
        scan_col_r <= '0;
        scan_row_r <= scan_row_r + btfre_pkg::coord_t'(1);
      end else begin
        scan_col_r <= scan_col_r + btfre_pkg::coord_t'(1);
      end
    end
  end

  // Moved-cell write stage, in the cycle after the scan read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
    end else begin
      wr_vld_r <= (state_r == btfre_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= {scan_dest.row, scan_dest.col};
  end

  // Bank requests: the active bank serves items and scan reads, the spare takes moves.
  btfre_pkg::bank_req_t act_req;
  btfre_pkg::bank_req_t spr_req;
  btfre_pkg::bank_req_t bank0_req;
  btfre_pkg::bank_req_t bank1_req;
  btfre_pkg::data_t     bank0_rdata;
  btfre_pkg::data_t     bank1_rdata;
  btfre_pkg::data_t     act_rdata;

  always_comb begin
    act_req.we    = in_acc && (in_op == btfre_pkg::OP_WRITE);
    act_req.waddr = {in_cell.row, in_cell.col};
    act_req.wdata = in_value;
    if (state_r == btfre_pkg::ST_SCAN) begin
      act_req.re    = 1'b1;
      act_req.raddr = {scan_row_r, scan_col_r};
    end else begin
      act_req.re    = in_acc && (in_op == btfre_pkg::OP_READ);
      act_req.raddr = {in_cell.row, in_cell.col};
    end
    spr_req.we    = wr_vld_r;
    spr_req.waddr = wr_addr_r;
    spr_req.wdata = act_rdata;
    spr_req.re    = 1'b0;
    spr_req.raddr = '0;
  end

  assign bank0_req = bank_r ? spr_req : act_req;
  assign bank1_req = bank_r ? act_req : spr_req;
  assign act_rdata = bank_r ? bank1_rdata : bank0_rdata;

  btfre_bank u_bank0 (
    .clk   (clk),
    .req   (bank0_req),
    .rdata (bank0_rdata)
  );

  btfre_bank u_bank1 (
    .clk   (clk),
    .req   (bank1_req),
    .rdata (bank1_rdata)
  );

  // Pending result of the item in progress.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_status_r <= (in_op == btfre_pkg::OP_XFORM) && lvl_bad;
      pend_data_r   <= '0;
    end else if (state_r == btfre_pkg::ST_READ) begin
      pend_data_r   <= act_rdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == btfre_pkg::ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == btfre_pkg::ST_DONE && out_free) begin
      out_status_r <= pend_status_r;
      out_data_r   <= pend_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

  // An accepted beat always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != btfre_pkg::ST_IDLE)
    else $error("accepted beat did not start an item");

  // The banks swap exactly after a drain cycle.
  a_bank_swap_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == btfre_pkg::ST_DRAIN) |=> bank_r != $past(bank_r))
    else $error("banks did not swap at end of transform");

  a_bank_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != btfre_pkg::ST_DRAIN) |=> bank_r == $past(bank_r))
    else $error("banks swapped outside a transform");

  // Moved cells are written only while a transform runs.
  a_spare_write_in_xform: assert property (@(posedge clk) disable iff (!rst_n)
    wr_vld_r |-> (state_r == btfre_pkg::ST_SCAN || state_r == btfre_pkg::ST_DRAIN))
    else $error("spare bank written outside a transform");

  // A result appears only from the done state.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == btfre_pkg::ST_DONE))
    else $error("result raised outside the done state");

endmodule

@@ bench/tb_block_tile_flip_rotate_engine.sv @@
// Self-checking testbench for block_tile_flip_rotate_engine: cell writes, reads and
// all eight tile transforms, checked against a two-bank grid predictor over many sizes.
// Depends on btfre_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb_block_tile_flip_rotate_engine;

  localparam int SIDE = 1 << btfre_pkg::MAX_LOG_SIZE;

  // One input beat, split into its fields.
  typedef struct packed {
    btfre_pkg::op_t    op;
    btfre_pkg::coord_t row;
    btfre_pkg::coord_t col;
    btfre_pkg::data_t  value;
    btfre_pkg::xform_t xf;
    btfre_pkg::log_t   lvl;
  } beat_t;

  // One result beat.
  typedef struct packed {
    logic             status;
    btfre_pkg::data_t value;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;   // [1:0] operation
  logic [39:0] in_tdata = '0;   // [6:0] row, [13:7] col, [29:14] cell_value,
                                // [32:30] transform, [35:33] level, rest zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tuser;       // [0] status
  logic [15:0] out_tdata;       // [15:0] read_value
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;

  // Predicted grid: both banks, with a flag per cell that says it holds written data.
  btfre_pkg::data_t bank_cells [2][btfre_pkg::CELL_COUNT];
  bit               bank_live [2][btfre_pkg::CELL_COUNT];
  bit               sel = 1'b0;
  btfre_pkg::log_t  grid_cfg = btfre_pkg::log_t'(7);

  reply_t replies_due [$];
  int     mismatches = 0;
  int     results_checked = 0;
  int     beats_sent = 0;
  int     xforms_sent = 0;
  int     wide_xforms_left = 2;
  int     stall_left = 0;
  bit     quiet = 1'b0;

  block_tile_flip_rotate_engine DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Run limit, far above the slowest legal run.
  initial begin
    #(8_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // The log2 of the grid side in use: a zero register acts as one.
  function automatic int grid_side_log();
    int s;
    s = grid_cfg;
    if (s < 1) s = 1;
    if (s > btfre_pkg::MAX_LOG_SIZE) s = btfre_pkg::MAX_LOG_SIZE;
    return s;
  endfunction

  // Move every cell of the active n x n region into the spare bank, then swap banks.
  function automatic void shuffle_grid(btfre_pkg::xform_t xf, int lv, int s);
    int n, om, tl, r, c, tr, tc, orr, oc, dr, dc, dst, src;
    n  = 1 << s;
    om = (1 << lv) - 1;
    tl = (n >> lv) - 1;
    for (r = 0; r < n; r++) begin
      for (c = 0; c < n; c++) begin
        tr  = r >> lv;
        tc  = c >> lv;
        orr = r & om;
        oc  = c & om;
        dr  = r;
        dc  = c;
        case (xf)
          btfre_pkg::XF_FLIP_ROWS:    dr = (tr << lv) | (om - orr);
          btfre_pkg::XF_FLIP_COLS:    dc = (tc << lv) | (om - oc);
          btfre_pkg::XF_ROT_TILE_CW: begin
            dr = (tr << lv) | oc;
            dc = (tc << lv) | (om - orr);
          end
          btfre_pkg::XF_ROT_TILE_CCW: begin
            dr = (tr << lv) | (om - oc);
            dc = (tc << lv) | orr;
          end
          btfre_pkg::XF_REV_ROWS:     dr = ((tl - tr) << lv) | orr;
          btfre_pkg::XF_REV_COLS:     dc = ((tl - tc) << lv) | oc;
          btfre_pkg::XF_ROT_ARR_CW: begin
            dr = (tc << lv) | orr;
            dc = ((tl - tr) << lv) | oc;
          end
          default: begin
            dr = ((tl - tc) << lv) | orr;
            dc = (tr << lv) | oc;
          end
        endcase
        dst = (dr & (n - 1)) * SIDE + (dc & (n - 1));
        src = r * SIDE + c;
        bank_cells[!sel][dst] = bank_cells[sel][src];
        bank_live[!sel][dst]  = bank_live[sel][src];
      end
    end
    sel = !sel;
  endfunction

  // Expected result of one beat; updates the predicted grid on the way.
  function automatic reply_t engine_outcome(beat_t b);
    reply_t rep;
    int s, nm, idx;
    rep = '0;
    s   = grid_side_log();
    nm  = (1 << s) - 1;
    idx = (b.row & nm) * SIDE + (b.col & nm);
    case (b.op)
      btfre_pkg::OP_WRITE: begin
        bank_cells[sel][idx] = b.value;
        bank_live[sel][idx]  = 1'b1;
      end
      btfre_pkg::OP_XFORM: begin
        if (b.lvl > s) rep.status = 1'b1;
        else shuffle_grid(b.xf, b.lvl, s);
      end
      btfre_pkg::OP_READ:  rep.value = bank_cells[sel][idx];
      default:  ;
    endcase
    return rep;
  endfunction

  function automatic beat_t make_beat(btfre_pkg::op_t op, int r, int c, int v, int xf,
                                      int lvl);
    beat_t b;
    b.op    = op;
    b.row   = btfre_pkg::coord_t'(r);
    b.col   = btfre_pkg::coord_t'(c);
    b.value = btfre_pkg::data_t'(v);
    b.xf    = btfre_pkg::xform_t'(xf);
    b.lvl   = btfre_pkg::log_t'(lvl);
    return b;
  endfunction

  // Result side: random back-pressure bursts unless the run is in its quiet part.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result beat with none expected: status %0b value %h",
                 $time, out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0b actual %0b", $time, want.status, out_tuser);
          mismatches++;
        end
        if (out_tdata !== want.value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.value, out_tdata);
          mismatches++;
        end
        results_checked++;
      end
    end
  end

  // Sender idles for a number of cycles.
  task automatic hold_input(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Send one beat and wait until it is taken.
  task automatic send_beat(beat_t b);
    if (!quiet && $urandom_range(0, 3) == 0) hold_input($urandom_range(1, 10));
    replies_due.push_back(engine_outcome(b));
    in_tuser  <= b.op;
    in_tdata  <= {4'b0, b.lvl, b.xf, b.value, b.col, b.row};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    if (b.op == btfre_pkg::OP_XFORM) xforms_sent++;
  endtask

  // Stop sending until every expected result beat has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // Change the grid size while the engine is idle.
  task automatic set_grid_size(int v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 3'(v);
    grid_cfg = btfre_pkg::log_t'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_random_cell();
    send_beat(make_beat(btfre_pkg::OP_WRITE, $urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 65535), $urandom_range(0, 7), $urandom_range(0, 7)));
  endtask

  // Read a written cell, with random wrap bits above the grid size; if none, write one.
  task automatic read_live_cell();
    int s, nm, r, c, k;
    int spots[$];
    s  = grid_side_log();
    nm = (1 << s) - 1;
    for (r = 0; r <= nm; r++)
      for (c = 0; c <= nm; c++)
        if (bank_live[sel][r * SIDE + c]) spots.push_back(r * SIDE + c);
    if (spots.size() == 0) begin
      write_random_cell();
    end else begin
      k = spots[$urandom_range(0, spots.size() - 1)];
      r = (k / SIDE) | ($urandom_range(0, 127) & ~nm & 127);
      c = (k % SIDE) | ($urandom_range(0, 127) & ~nm & 127);
      send_beat(make_beat(btfre_pkg::OP_READ, r, c, $urandom_range(0, 65535),
                          $urandom_range(0, 7), $urandom_range(0, 7)));
    end
  endtask

  task automatic send_xform(int xf, int lvl);
    send_beat(make_beat(btfre_pkg::OP_XFORM, $urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 65535), xf, lvl));
  endtask

  // Corners of the full grid after reset, plus the unused operation code.
  task automatic test_corner_cells();
    send_beat(make_beat(btfre_pkg::OP_WRITE, 0, 0, 16'h0000, 0, 0));
    send_beat(make_beat(btfre_pkg::OP_WRITE, 127, 127, 16'hFFFF, 7, 7));
    send_beat(make_beat(btfre_pkg::OP_WRITE, 0, 127, 16'h5555, 2, 5));
    send_beat(make_beat(btfre_pkg::OP_WRITE, 127, 0, 16'hAAAA, 5, 2));
    send_beat(make_beat(btfre_pkg::OP_READ, 127, 127, 0, 0, 0));
    send_beat(make_beat(btfre_pkg::OP_READ, 0, 127, 16'hFFFF, 7, 7));
    send_beat(make_beat(btfre_pkg::OP_READ, 127, 0, 0, 0, 0));
    send_beat(make_beat(btfre_pkg::OP_NONE, 127, 127, 16'hFFFF, 7, 7));
  endtask

  // Whole-grid transforms at the largest size: one tile the size of the grid, and 1x1 tiles.
  task automatic test_full_grid_xforms();
    send_xform(btfre_pkg::XF_ROT_TILE_CW, 7);
    read_live_cell();
    send_xform(btfre_pkg::XF_ROT_ARR_CCW, 0);
    read_live_cell();
  endtask

  // A zero size register acts as a 2x2 grid; indices wrap and oversize levels are refused.
  task automatic test_tiny_grid();
    set_grid_size(0);
    send_beat(make_beat(btfre_pkg::OP_WRITE, 0, 0, 16'h0001, 0, 0));
    send_beat(make_beat(btfre_pkg::OP_WRITE, 127, 0, 16'h0002, 0, 0));
    send_beat(make_beat(btfre_pkg::OP_WRITE, 126, 127, 16'h0003, 0, 0));
    send_beat(make_beat(btfre_pkg::OP_WRITE, 125, 125, 16'h0004, 0, 0));
    send_xform(btfre_pkg::XF_ROT_TILE_CW, 2);
    send_xform(btfre_pkg::XF_FLIP_ROWS, 7);
    send_xform(btfre_pkg::XF_FLIP_ROWS, 1);
    send_xform(btfre_pkg::XF_FLIP_COLS, 1);
    send_xform(btfre_pkg::XF_ROT_TILE_CW, 1);
    send_xform(btfre_pkg::XF_ROT_TILE_CCW, 1);
    send_xform(btfre_pkg::XF_REV_ROWS, 0);
    send_xform(btfre_pkg::XF_REV_COLS, 0);
    send_xform(btfre_pkg::XF_ROT_ARR_CW, 0);
    send_xform(btfre_pkg::XF_ROT_ARR_CCW, 0);
    read_live_cell();
    read_live_cell();
  endtask

  // One grid size: seed some cells, then random writes, reads, transforms and no-ops.
  task automatic test_random_phase(int size_code, int count);
    int s, pick, lvl;
    set_grid_size(size_code);
    s = grid_side_log();
    repeat (4) write_random_cell();
    repeat (count) begin
      if ($urandom_range(0, 99) < 8) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        write_random_cell();
      end else if (pick < 62) begin
        read_live_cell();
      end else if (pick < 92) begin
        if (s < btfre_pkg::MAX_LOG_SIZE && $urandom_range(0, 5) == 0) begin
          lvl = $urandom_range(s + 1, 7);
        end else begin
          lvl = $urandom_range(0, s);
        end
        // Full-size transforms are slow, so only a few of them run.
        if (s == btfre_pkg::MAX_LOG_SIZE && wide_xforms_left == 0) begin
          read_live_cell();
        end else begin
          if (s == btfre_pkg::MAX_LOG_SIZE) wide_xforms_left--;
          send_xform($urandom_range(0, 7), lvl);
        end
      end else begin
        send_beat(make_beat(btfre_pkg::OP_NONE, $urandom_range(0, 127),
                            $urandom_range(0, 127), $urandom_range(0, 65535),
                            $urandom_range(0, 7), $urandom_range(0, 7)));
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_cells();
    test_full_grid_xforms();
    test_tiny_grid();
    test_random_phase(1, 5);
    test_random_phase(3, 5);
    test_random_phase(2, 5);
    test_random_phase(5, 5);
    test_random_phase(4, 5);
    test_random_phase(6, 5);
    test_random_phase(7, 5);
    quiet = 1'b1;
    test_random_phase(2, 5);
    drain_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d beats (%0d transforms) over grid sides 2 to 128; checked %0d results.",
             beats_sent, xforms_sent, results_checked);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/btfre_pkg.sv
rtl/core/btfre_bank.sv
rtl/core/block_tile_flip_rotate_engine.sv
bench/tb_block_tile_flip_rotate_engine.sv
